// File: rtl/lcdbw_pkg.sv
package lcdbw_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      OP_CMD  = 2'd0,
      OP_DATA = 2'd1,
      OP_GOTO = 2'd2,
      OP_INIT = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_BUS_MODE      = 2'd0,
      CSR_PULSE_HOLD    = 2'd1,
      CSR_POWER_ON_WAIT = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   localparam logic [7:0] FN_SET_8BIT   = 8'h38;
   localparam logic [3:0] FN_SET_NIB_A  = 4'h2;
   localparam logic [3:0] FN_SET_NIB_B  = 4'h8;
   localparam logic [7:0] DISPLAY_ON    = 8'h0C;
   localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
   localparam logic [7:0] ROW1_OFFSET   = 8'h40;
   localparam logic [7:0] DDRAM_FLAG    = 8'h80;

   localparam logic [7:0] RST_PULSE_HOLD = 8'd2;
   localparam logic [7:0] RST_POWER_WAIT = 8'd40;

   // pulse step within one job: up to seven pulses
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] INIT4_LAST = 3'd6;
   localparam logic [STEP_W-1:0] INIT8_LAST = 3'd2;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // one classified job
   typedef struct packed {
      logic       is_init;
      logic       rs;
      logic [7:0] value;
   } job_type;

   // live configuration
   typedef struct packed {
      logic       bus_mode;
      logic [7:0] pulse_hold;
      logic [7:0] power_wait;
   } cfg_type;

   // bus value of an initialize pulse, step by step
   function automatic logic [7:0] init_bus(input logic nibble_mode,
                                           input logic [STEP_W-1:0] step);
      logic [7:0] v;
      v = 8'h00;
      if (!nibble_mode) begin
         case (step)
            3'd0:    v = FN_SET_8BIT;
            3'd1:    v = DISPLAY_ON;
            3'd2:    v = CLEAR_DISPLAY;
            default: v = 8'h00;
         endcase
      end else begin
         case (step)
            3'd0:    v = {4'h0, FN_SET_NIB_A};
            3'd1:    v = {4'h0, FN_SET_NIB_A};
            3'd2:    v = {4'h0, FN_SET_NIB_B};
            3'd3:    v = {4'h0, DISPLAY_ON[7:4]};
            3'd4:    v = {4'h0, DISPLAY_ON[3:0]};
            3'd5:    v = {4'h0, CLEAR_DISPLAY[7:4]};
            3'd6:    v = {4'h0, CLEAR_DISPLAY[3:0]};
            default: v = 8'h00;
         endcase
      end
      return v;
   endfunction

endpackage

// File: rtl/lcdbw_ifs.sv
// request channel
interface lcdbw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] byte_value;
   logic [5:0] column;
   logic       row;

   modport source (output valid, operation, byte_value, column, row, input ready);
   modport sink   (input valid, operation, byte_value, column, row, output ready);
endinterface

// pulse channel
interface lcdbw_rsp_if;
   logic       valid;
   logic       ready;
   logic       register_select;
   logic [7:0] bus_value;
   logic [7:0] wait_before_ms;
   logic [7:0] enable_high_ms;
   logic       last_pulse;

   modport source (output valid, register_select, bus_value, wait_before_ms,
                   enable_high_ms, last_pulse, input ready);
   modport sink   (input valid, register_select, bus_value, wait_before_ms,
                   enable_high_ms, last_pulse, output ready);
endinterface

// File: rtl/char_lcd_bus_writer_core.sv
// Character LCD bus writer.
// req_ch carries one request per item: command byte, data byte, go to
// column/row, or initialize. rsp_ch carries one item per enable pulse, in
// order, with last_pulse set on the final pulse of each request.
// The csr_ port writes bus_mode, pulse_hold_ms and power_on_wait_ms; write
// only while no request is in flight.
// The request is written into the job queue, and the sequencer then loads its
// first pulse into the pulse output register. A request yields 1 or 3 pulses in
// eight-bit mode and 2 or 7 in four-bit mode; the back end emits one pulse per
// cycle while a job is queued and rsp_ch does not stall. A two-entry job queue
// between the request classifier and the pulse sequencer lets requests be taken back to back.
// When rsp_ch stalls the pulse output register holds, the sequencer stops and
// the queue fills; req_ch.ready drops once the queue is full.
// Reset empties the queue and the output register and sets bus_mode to 0,
// pulse_hold_ms to 2 and power_on_wait_ms to 40.
module char_lcd_bus_writer_core (
   input  logic        clock,
   input  logic        reset,
   lcdbw_req_if.sink   req_ch,
   lcdbw_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic               bus_mode_ff;
   logic [7:0]         pulse_hold_ff;
   logic [7:0]         power_wait_ff;
   lcdbw_pkg::cfg_type cfg;

   logic               q_full;
   logic               push;
   lcdbw_pkg::job_type push_job;
   logic               head_valid;
   lcdbw_pkg::job_type head_job;
   logic               pop;
   logic [lcdbw_pkg::STEP_W-1:0] step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_mode_ff   <= 1'b0;
         pulse_hold_ff <= lcdbw_pkg::RST_PULSE_HOLD;
         power_wait_ff <= lcdbw_pkg::RST_POWER_WAIT;
      end else if (csr_we) begin
         case (lcdbw_pkg::csr_index_type'(csr_index))
            lcdbw_pkg::CSR_BUS_MODE:      bus_mode_ff   <= csr_wdata[0];
            lcdbw_pkg::CSR_PULSE_HOLD:    pulse_hold_ff <= csr_wdata;
            lcdbw_pkg::CSR_POWER_ON_WAIT: power_wait_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.bus_mode   = bus_mode_ff;
   assign cfg.pulse_hold = pulse_hold_ff;
   assign cfg.power_wait = power_wait_ff;

   lcdbw_front u_front (
      .req    (req_ch),
      .q_full (q_full),
      .push   (push),
      .job    (push_job)
   );

   lcdbw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   lcdbw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .step       (step),
      .rsp        (rsp_ch)
   );

   // the sequencer never runs past the longest pulse script
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step <= lcdbw_pkg::INIT4_LAST)
      else $error("pulse step out of range");

   // a job leaves the queue only when there is one
   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty job queue");

   // a finished pulse marked last always ends its job: step restarts
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      pop |=> step == '0)
      else $error("step not cleared after last pulse");

   // a mid-job step implies a job is still waiting at the head
   a_step_has_job: assert property (@(posedge clock) disable iff (reset)
      step != '0 |-> head_valid)
      else $error("pulse step active without a job");

endmodule

// File: rtl/lcdbw_front.sv
module lcdbw_front (
   lcdbw_req_if.sink         req,
   input  logic              q_full,
   output logic              push,
   output lcdbw_pkg::job_type job
);

   lcdbw_pkg::op_type op;
   logic [7:0]        ddram_addr;

   assign op = lcdbw_pkg::op_type'(req.operation);

   // DDRAM address: column, plus row offset, with the set-address flag
   assign ddram_addr = (8'(req.column) + (req.row ? lcdbw_pkg::ROW1_OFFSET : 8'h00))
                       | lcdbw_pkg::DDRAM_FLAG;

   // classify the request into a job for the back end
   always_comb begin
      job.is_init = (op == lcdbw_pkg::OP_INIT);
      job.rs      = (op == lcdbw_pkg::OP_DATA);
      job.value   = (op == lcdbw_pkg::OP_GOTO) ? ddram_addr : req.byte_value;
   end

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

endmodule

// File: rtl/lcdbw_queue.sv
module lcdbw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lcdbw_pkg::job_type push_job,
   output logic               full,
   output logic               head_valid,
   output lcdbw_pkg::job_type head_job,
   input  logic               pop
);

   lcdbw_pkg::job_type                  mem [lcdbw_pkg::QDEPTH];
   logic [lcdbw_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [lcdbw_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [lcdbw_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign full       = (count_ff == lcdbw_pkg::QCNT_W'(lcdbw_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/lcdbw_back.sv
module lcdbw_back (
   input  logic               clock,
   input  logic               reset,
   input  lcdbw_pkg::cfg_type cfg,
   input  logic               head_valid,
   input  lcdbw_pkg::job_type head_job,
   output logic               pop,
   output logic [lcdbw_pkg::STEP_W-1:0] step,
   lcdbw_rsp_if.source        rsp
);

   logic [lcdbw_pkg::STEP_W-1:0] step_ff, step_in;
   logic                         valid_ff, valid_in;
   logic                         rs_ff;
   logic [7:0]                   bus_ff;
   logic [7:0]                   wait_ff;
   logic [7:0]                   hold_ff;
   logic                         last_ff;

   logic                         load;
   logic                         p_rs;
   logic [7:0]                   p_bus;
   logic [7:0]                   p_wait;
   logic                         p_last;

   // next pulse of the job at the queue head
   always_comb begin
      p_rs   = head_job.is_init ? 1'b0 : head_job.rs;
      p_wait = (head_job.is_init && step_ff == '0) ? cfg.power_wait : 8'h00;
      if (head_job.is_init) begin
         p_bus  = lcdbw_pkg::init_bus(cfg.bus_mode, step_ff);
         p_last = cfg.bus_mode ? (step_ff == lcdbw_pkg::INIT4_LAST)
                               : (step_ff == lcdbw_pkg::INIT8_LAST);
      end else if (cfg.bus_mode) begin
         p_bus  = (step_ff == '0) ? {4'h0, head_job.value[7:4]}
                                  : {4'h0, head_job.value[3:0]};
         p_last = (step_ff != '0);
      end else begin
         p_bus  = head_job.value;
         p_last = 1'b1;
      end
   end

   // output register takes a pulse when empty or being drained
   assign load = head_valid && (!valid_ff || rsp.ready);
   assign pop  = load && p_last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = p_last ? '0 : step_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // pulse payload
   always_ff @(posedge clock) begin
      if (load) begin
         rs_ff   <= p_rs;
         bus_ff  <= p_bus;
         wait_ff <= p_wait;
         hold_ff <= cfg.pulse_hold;
         last_ff <= p_last;
      end
   end

   assign step                = step_ff;
   assign rsp.valid           = valid_ff;
   assign rsp.register_select = rs_ff;
   assign rsp.bus_value       = bus_ff;
   assign rsp.wait_before_ms  = wait_ff;
   assign rsp.enable_high_ms  = hold_ff;
   assign rsp.last_pulse      = last_ff;

endmodule

// File: verif/char_lcd_bus_writer_core_tb.sv
module char_lcd_bus_writer_core_tb;
   import lcdbw_pkg::*;

   // LCD controller codes, kept here so a wrong constant in the design shows up
   localparam logic [7:0] LCD_FUNC_SET_8   = 8'h38;
   localparam logic [7:0] LCD_FUNC_NIB_HI  = 8'h02;
   localparam logic [7:0] LCD_FUNC_NIB_LO  = 8'h08;
   localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   localparam logic [7:0] LCD_ROW1_BASE    = 8'h40;
   localparam logic [7:0] LCD_DDRAM_SET    = 8'h80;
   localparam logic       RS_COMMAND       = 1'b0;
   localparam logic       RS_DATA          = 1'b1;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 22;

   typedef struct {
      op_type     op;
      logic [7:0] byte_value;
      logic [5:0] column;
      logic       row;
   } lcd_req_t;

   typedef struct {
      logic       rs;
      logic [7:0] bus;
      logic [7:0] wait_ms;
      logic [7:0] hold_ms;
      logic       last;
   } pulse_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_we    = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_wdata = 8'd0;

   lcdbw_req_if req_if ();
   lcdbw_rsp_if rsp_if ();

   char_lcd_bus_writer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the writer's registers
   logic       mode_4bit;
   logic [7:0] hold_ms_reg;
   logic [7:0] power_wait_reg;

   lcd_req_t req_pending_q[$];
   pulse_t   pulse_expect_q[$];
   lcd_req_t cur_req;

   int  error_count  = 0;
   int  pulse_count  = 0;
   int  req_count    = 0;
   int  op_count[4]  = '{0, 0, 0, 0};
   int  setting_count = 1;
   int  cycle_count  = 0;
   int  gap_left     = 0;
   int  stall_left   = 0;
   bit  idle_on      = 1'b1;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   function automatic void add_pulse(logic rs, logic [7:0] bus, logic [7:0] wait_ms,
                                     logic last);
      pulse_t p;
      p.rs      = rs;
      p.bus     = bus;
      p.wait_ms = wait_ms;
      p.hold_ms = hold_ms_reg;
      p.last    = last;
      pulse_expect_q.push_back(p);
   endfunction

   // one byte: whole in eight-bit mode, high nibble then low nibble otherwise
   function automatic void add_byte(logic rs, logic [7:0] value, logic [7:0] wait_ms,
                                    logic last);
      if (!mode_4bit) begin
         add_pulse(rs, value, wait_ms, last);
      end else begin
         add_pulse(rs, {4'h0, value[7:4]}, wait_ms, 1'b0);
         add_pulse(rs, {4'h0, value[3:0]}, 8'd0, last);
      end
   endfunction

   // pulses one accepted request produces
   function automatic void predict_pulses(lcd_req_t r);
      logic [7:0] addr;
      case (r.op)
         OP_CMD: begin
            add_byte(RS_COMMAND, r.byte_value, 8'd0, 1'b1);
         end
         OP_DATA: begin
            add_byte(RS_DATA, r.byte_value, 8'd0, 1'b1);
         end
         OP_GOTO: begin
            addr = ({2'b00, r.column} + (r.row ? LCD_ROW1_BASE : 8'h00)) | LCD_DDRAM_SET;
            add_byte(RS_COMMAND, addr, 8'd0, 1'b1);
         end
         default: begin
            if (!mode_4bit) begin
               add_pulse(RS_COMMAND, LCD_FUNC_SET_8, power_wait_reg, 1'b0);
            end else begin
               add_pulse(RS_COMMAND, LCD_FUNC_NIB_HI, power_wait_reg, 1'b0);
               add_pulse(RS_COMMAND, LCD_FUNC_NIB_HI, 8'd0, 1'b0);
               add_pulse(RS_COMMAND, LCD_FUNC_NIB_LO, 8'd0, 1'b0);
            end
            add_byte(RS_COMMAND, LCD_DISPLAY_ON, 8'd0, 1'b0);
            add_byte(RS_COMMAND, LCD_CLEAR, 8'd0, 1'b1);
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      logic nxt_valid;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         nxt_valid = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            predict_pulses(cur_req);
            req_count++;
            op_count[cur_req.op]++;
            nxt_valid = 1'b0;
            gap_left  = idle_on ? pick_gap() : 0;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_pending_q.size() > 0) begin
               cur_req = req_pending_q.pop_front();
               nxt_valid = 1'b1;
               req_if.operation  <= cur_req.op;
               req_if.byte_value <= cur_req.byte_value;
               req_if.column     <= cur_req.column;
               req_if.row        <= cur_req.row;
            end
         end
         req_if.valid <= nxt_valid;
      end
   end

   // pulse monitor and receiver stalls
   always @(posedge clock) begin
      pulse_t exp;
      logic   nxt_ready;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pulse_expect_q.size() == 0) begin
               flag_error($sformatf(
                  "unexpected pulse rs=%0d bus=%02h wait=%0d hold=%0d last=%0d",
                  rsp_if.register_select, rsp_if.bus_value, rsp_if.wait_before_ms,
                  rsp_if.enable_high_ms, rsp_if.last_pulse));
            end else begin
               exp = pulse_expect_q.pop_front();
               if (rsp_if.register_select !== exp.rs || rsp_if.bus_value !== exp.bus ||
                   rsp_if.wait_before_ms !== exp.wait_ms ||
                   rsp_if.enable_high_ms !== exp.hold_ms || rsp_if.last_pulse !== exp.last)
                  flag_error({
                     $sformatf("pulse %0d: exp rs=%0d bus=%02h wait=%0d hold=%0d last=%0d",
                               pulse_count, exp.rs, exp.bus, exp.wait_ms,
                               exp.hold_ms, exp.last),
                     $sformatf(", got rs=%0d bus=%02h wait=%0d hold=%0d last=%0d",
                               rsp_if.register_select, rsp_if.bus_value,
                               rsp_if.wait_before_ms, rsp_if.enable_high_ms,
                               rsp_if.last_pulse)});
            end
            pulse_count++;
         end
         nxt_ready = (stall_left == 0);
         if (stall_left > 0) stall_left--;
         else if (idle_on) stall_left = pick_gap();
         rsp_if.ready <= nxt_ready;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic csr_write(csr_index_type idx, logic [7:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BUS_MODE:      mode_4bit      = data[0];
         CSR_PULSE_HOLD:    hold_ms_reg    = data;
         CSR_POWER_ON_WAIT: power_wait_reg = data;
         default: ;
      endcase
   endtask

   // hold off until every request is taken and every pulse has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (req_pending_q.size() != 0 || req_if.valid || pulse_expect_q.size() != 0);
   endtask

   task automatic set_config(logic mode, logic [7:0] hold, logic [7:0] pwait);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(CSR_BUS_MODE, {7'd0, mode});
      csr_write(CSR_PULSE_HOLD, hold);
      csr_write(CSR_POWER_ON_WAIT, pwait);
      setting_count++;
      @(negedge clock);
   endtask

   function automatic void queue_req(op_type op, logic [7:0] b, logic [5:0] col, logic row);
      lcd_req_t r;
      r.op = op;
      r.byte_value = b;
      r.column = col;
      r.row = row;
      req_pending_q.push_back(r);
   endfunction

   function automatic logic [7:0] pick_extreme(logic [7:0] lo);
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      req_if.valid      = 1'b0;
      req_if.operation  = OP_CMD;
      req_if.byte_value = 8'd0;
      req_if.column     = 6'd0;
      req_if.row        = 1'b0;
      rsp_if.ready      = 1'b0;
      mode_4bit         = 1'b0;
      hold_ms_reg       = 8'd2;
      power_wait_reg    = 8'd40;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values, eight-bit bus: field extremes and every operation
      queue_req(OP_CMD,  8'h00, 6'd0,  1'b0);
      queue_req(OP_CMD,  8'hFF, 6'd63, 1'b1);
      queue_req(OP_DATA, 8'h00, 6'd0,  1'b0);
      queue_req(OP_DATA, 8'hFF, 6'd0,  1'b0);
      queue_req(OP_DATA, 8'hA5, 6'd21, 1'b1);
      queue_req(OP_GOTO, 8'hFF, 6'd0,  1'b0);
      queue_req(OP_GOTO, 8'h00, 6'd63, 1'b1);
      queue_req(OP_GOTO, 8'h5A, 6'd63, 1'b0);
      queue_req(OP_GOTO, 8'h00, 6'd0,  1'b1);
      queue_req(OP_INIT, 8'hFF, 6'd63, 1'b1);
      queue_req(OP_INIT, 8'h00, 6'd0,  1'b0);

      // four-bit bus, zero hold time, longest power-on wait
      set_config(1'b1, 8'd0, 8'd255);
      queue_req(OP_CMD,  8'h5A, 6'd42, 1'b1);
      queue_req(OP_DATA, 8'hC3, 6'd0,  1'b0);
      queue_req(OP_GOTO, 8'h00, 6'd37, 1'b1);
      queue_req(OP_INIT, 8'h00, 6'd0,  1'b0);
      queue_req(OP_INIT, 8'hFF, 6'd63, 1'b1);
      queue_req(OP_DATA, 8'h0F, 6'd0,  1'b0);

      // four-bit bus, longest hold, no power-on wait; unused index must be ignored
      set_config(1'b1, 8'd255, 8'd0);
      csr_write(CSR_UNUSED, 8'($urandom_range(0, 255)));
      @(negedge clock);
      queue_req(OP_CMD,  8'hF0, 6'd0,  1'b0);
      queue_req(OP_INIT, 8'h00, 6'd0,  1'b0);
      queue_req(OP_GOTO, 8'h00, 6'd0,  1'b0);

      // random requests under changing settings
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_config(ph[0], pick_extreme(8'd1), pick_extreme(8'd0));
         idle_on = (ph != 2);
         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_req(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pulse_expect_q.size() != 0)
         flag_error($sformatf("%0d pulses never arrived", pulse_expect_q.size()));

      $display("covered %0d requests (cmd %0d, data %0d, goto %0d, init %0d)",
               req_count, op_count[OP_CMD], op_count[OP_DATA], op_count[OP_GOTO],
               op_count[OP_INIT]);
      $display("checked %0d pulses over %0d register settings, %0d errors",
               pulse_count, setting_count, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
